FILE: rtl/snrb_pkg.sv
// Shared types and constants of the serial number reorder buffer.
package snrb_pkg;

	localparam int SEQ_W = 16;
	localparam int HOLD_LIMIT = 30;

	typedef logic [SEQ_W-1:0] seq_t;

	localparam logic [1:0] KIND_DELIVERED = 2'd0;
	localparam logic [1:0] KIND_HELD      = 2'd1;
	localparam logic [1:0] KIND_DUPLICATE = 2'd2;
	localparam logic [1:0] KIND_FULL      = 2'd3;

	typedef struct packed {
		logic insert;
		logic shift;
		seq_t new_seq;
		seq_t new_handle;
		seq_t expected;
		seq_t fwd_dist;
	} snrb_bcast_t;

endpackage

FILE: rtl/serial_number_reorder_buffer.sv
// Receive-side reorder buffer for 16-bit wrap-around packet sequence numbers.
//
// One packet is taken at a time. An accepted packet first passes the evaluate state, in which
// every cell of the hold chain does its compare, and its first result is then loaded into the
// output register. An in-order packet then gives one more delivery per cycle, while the output
// does not stall, for each held packet that has become consecutive, all taken from the head cell
// while the chain shifts toward it. The input stays stalled until the last result has been
// loaded. A stall on the output holds the pending result until the output register is free.
// The hold chain is tracked by a fill count, so the block is ready right after reset.
module serial_number_reorder_buffer import snrb_pkg::*; #(
	parameter int HOLD_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  seq_t       in_sequence,
	input  seq_t       in_handle,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_kind,
	output seq_t       out_sequence,
	output seq_t       out_handle,
	output seq_t       expected_next,
	output logic       last_of_run
);

	localparam int CW = $clog2(HOLD_DEPTH + 1);
	localparam int CAP = (HOLD_LIMIT < HOLD_DEPTH) ? HOLD_LIMIT : HOLD_DEPTH;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_INS   = 3'd2;
	localparam logic [2:0] S_ONE   = 3'd3;
	localparam logic [2:0] S_DELIV = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] held_count_q;
	seq_t          expected_q;
	seq_t          seq_q;
	seq_t          handle_q;
	seq_t          dist_q;
	logic [1:0]    kind_q;

	logic          out_valid_q;
	logic [1:0]    result_kind_q;
	seq_t          out_sequence_q;
	seq_t          out_handle_q;
	seq_t          expected_next_q;
	logic          last_of_run_q;

	seq_t          cell_seq [HOLD_DEPTH];
	seq_t          cell_handle [HOLD_DEPTH];
	seq_t          left_seq [HOLD_DEPTH];
	seq_t          left_handle [HOLD_DEPTH];
	seq_t          right_seq [HOLD_DEPTH];
	seq_t          right_handle [HOLD_DEPTH];
	logic [HOLD_DEPTH-1:0] greater;
	logic [HOLD_DEPTH-1:0] dup_flag;
	logic [HOLD_DEPTH-1:0] prev_greater;
	logic [HOLD_DEPTH-1:0] occupied;

	snrb_bcast_t   bcast;
	logic          out_free;
	logic          dup_any;
	logic          emit;
	logic [1:0]    kind_n;
	seq_t          oseq_n;
	seq_t          ohandle_n;
	seq_t          exp_n;
	logic          last_n;
	seq_t          exp_plus;

	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign dup_any   = |dup_flag;
	assign exp_plus  = expected_q + 16'd1;

	assign bcast.insert     = emit && (state_q == S_INS) && !dup_any;
	assign bcast.shift      = emit && (state_q == S_DRAIN);
	assign bcast.new_seq    = seq_q;
	assign bcast.new_handle = handle_q;
	assign bcast.expected   = expected_q;
	assign bcast.fwd_dist   = dist_q;

	for (genvar i = 0; i < HOLD_DEPTH; i++) begin : g_cell
		assign occupied[i] = (CW'(i) < held_count_q);
		if (i == 0) begin : g_head
			assign prev_greater[i] = 1'b0;
			assign left_seq[i]     = seq_q;
			assign left_handle[i]  = handle_q;
		end else begin : g_body
			assign prev_greater[i] = greater[i-1];
			assign left_seq[i]     = cell_seq[i-1];
			assign left_handle[i]  = cell_handle[i-1];
		end
		if (i == HOLD_DEPTH - 1) begin : g_tail
			assign right_seq[i]    = cell_seq[i];
			assign right_handle[i] = cell_handle[i];
		end else begin : g_inner
			assign right_seq[i]    = cell_seq[i+1];
			assign right_handle[i] = cell_handle[i+1];
		end

		snrb_cell u_cell (
			.clk          (clk),
			.bcast        (bcast),
			.occupied     (occupied[i]),
			.prev_greater (prev_greater[i]),
			.left_seq     (left_seq[i]),
			.left_handle  (left_handle[i]),
			.right_seq    (right_seq[i]),
			.right_handle (right_handle[i]),
			.seq_q        (cell_seq[i]),
			.handle_q     (cell_handle[i]),
			.greater_q    (greater[i]),
			.dup_q        (dup_flag[i])
		);
	end

	always_comb begin
		emit      = 1'b0;
		kind_n    = KIND_DELIVERED;
		oseq_n    = seq_q;
		ohandle_n = handle_q;
		exp_n     = expected_q;
		last_n    = 1'b1;
		unique case (state_q)
			S_INS: begin
				emit   = out_free;
				kind_n = dup_any ? KIND_DUPLICATE : KIND_HELD;
			end
			S_ONE: begin
				emit   = out_free;
				kind_n = kind_q;
			end
			S_DELIV: begin
				emit   = out_free;
				exp_n  = exp_plus;
				last_n = !((held_count_q != '0) && (cell_seq[0] == exp_plus));
			end
			S_DRAIN: begin
				emit      = out_free;
				oseq_n    = cell_seq[0];
				ohandle_n = cell_handle[0];
				exp_n     = exp_plus;
				last_n    = !((held_count_q > CW'(1)) && (cell_seq[1] == exp_plus));
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			held_count_q <= '0;
			expected_q   <= '0;
			kind_q       <= KIND_DUPLICATE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (dist_q == '0) begin
						state_q <= S_DELIV;
					end else if (dist_q[SEQ_W-1]) begin
						state_q <= S_ONE;
						kind_q  <= KIND_DUPLICATE;
					end else if (held_count_q >= CW'(CAP)) begin
						state_q <= S_ONE;
						kind_q  <= KIND_FULL;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (emit) begin
						state_q <= S_IDLE;
						if (!dup_any) begin
							held_count_q <= held_count_q + CW'(1);
						end
					end
				end
				S_ONE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				S_DELIV: begin
					if (emit) begin
						expected_q <= exp_plus;
						state_q    <= last_n ? S_IDLE : S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (emit) begin
						expected_q   <= exp_plus;
						held_count_q <= held_count_q - CW'(1);
						if (last_n) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			seq_q    <= in_sequence;
			handle_q <= in_handle;
			dist_q   <= in_sequence - expected_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_kind_q   <= kind_n;
			out_sequence_q  <= oseq_n;
			out_handle_q    <= ohandle_n;
			expected_next_q <= exp_n;
			last_of_run_q   <= last_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = result_kind_q;
	assign out_sequence  = out_sequence_q;
	assign out_handle    = out_handle_q;
	assign expected_next = expected_next_q;
	assign last_of_run   = last_of_run_q;

	// The hold never grows past its cap.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CW'(CAP))
		else $error("hold count exceeds its cap");

	// A held result adds exactly one entry to the chain.
	a_held_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && kind_n == KIND_HELD) |=> held_count_q == $past(held_count_q) + CW'(1))
		else $error("held result without a new chain entry");

	// Draining only runs while the head cell holds the expected sequence.
	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> (held_count_q != '0 && cell_seq[0] == expected_q))
		else $error("drain with a non-consecutive head entry");

	// Every delivery advances the expected sequence by one.
	a_deliver_step: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && kind_n == KIND_DELIVERED) |=> expected_q == $past(expected_q) + 16'd1)
		else $error("delivery did not advance the expected sequence");

endmodule

FILE: rtl/snrb_cell.sv
// One slot of the sorted hold chain: a held packet plus its compare flags.
module snrb_cell import snrb_pkg::*; (
	input  logic        clk,
	input  snrb_bcast_t bcast,
	input  logic        occupied,
	input  logic        prev_greater,
	input  seq_t        left_seq,
	input  seq_t        left_handle,
	input  seq_t        right_seq,
	input  seq_t        right_handle,
	output seq_t        seq_q,
	output seq_t        handle_q,
	output logic        greater_q,
	output logic        dup_q
);

	seq_t dist_here;

	assign dist_here = seq_q - bcast.expected;

	always_ff @(posedge clk) begin
		greater_q <= !occupied || (dist_here > bcast.fwd_dist);
		dup_q     <= occupied && (seq_q == bcast.new_seq);
	end

	always_ff @(posedge clk) begin
		if (bcast.shift) begin
			seq_q    <= right_seq;
			handle_q <= right_handle;
		end else if (bcast.insert && greater_q) begin
			if (prev_greater) begin
				seq_q    <= left_seq;
				handle_q <= left_handle;
			end else begin
				seq_q    <= bcast.new_seq;
				handle_q <= bcast.new_handle;
			end
		end
	end

endmodule
